// ===== rtl/ampq_pkg.sv =====
// ============================================================================
// ampq_pkg
// Shared sizes, entry layout and action codes of the min-priority queue.
// ============================================================================
package ampq_pkg;

    // table geometry
    localparam int CAPACITY  = 256;
    localparam int ID_BITS   = 16;
    localparam int COST_BITS = 32;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = ID_BITS + COST_BITS;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [COST_BITS-1:0] cost;
    } t_entry;

    // operation codes carried by the action field
    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_EXTRACT  = 2'd1,
        ACT_DECREASE = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

endpackage

// ===== rtl/array_min_priority_queue.sv =====
// ============================================================================
// array_min_priority_queue
// Min-priority queue of (id, cost) words held unsorted in one entry RAM.
// ============================================================================
// Insert and clear go from acceptance straight to ST_FINISH. Extract-min and
// decrease-cost walk the held entries through the single RAM read port, one
// entry per cycle, over at most entry_count entries (CAPACITY at most);
// decrease-cost stops at the first matching id. One word is worked on at a
// time; the next input word is taken once the current result has been placed
// in the output register, even while that result still waits.
// Ties in extract go to the earliest entry; the last entry fills the hole.
module array_min_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_action,
    input  logic [ampq_pkg::ID_BITS-1:0]    i_key_id,
    input  logic [ampq_pkg::COST_BITS-1:0]  i_cost,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ampq_pkg::ID_BITS-1:0]    o_out_id,
    output logic                            o_found,
    output logic                            o_dropped,
    output logic                            o_lowered,
    output logic [ampq_pkg::CNT_BITS-1:0]   o_entry_count,
    output logic                            o_queue_empty
);

    import ampq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_MIN,
        ST_SCAN_KEY,
        ST_FINISH
    } t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   r_rd_idx;
    logic                  r_cmp_valid;
    logic [IDX_BITS-1:0]   r_cmp_idx;
    logic [IDX_BITS-1:0]   r_best_idx;
    logic [COST_BITS-1:0]  r_best_cost;
    logic [ID_BITS-1:0]    r_best_id;
    logic [ID_BITS-1:0]    r_key;
    logic [COST_BITS-1:0]  r_new_cost;
    logic [ID_BITS-1:0]    r_res_id;
    logic                  r_res_found;
    logic                  r_res_dropped;
    logic                  r_res_lowered;
    logic                  r_out_valid;

    logic                  in_accept;
    logic                  out_free;
    logic                  table_full;
    logic                  rd_en;
    logic [ENTRY_BITS-1:0] rd_bits;
    t_entry                rd_entry;
    logic                  scan_last;
    logic                  min_take;
    logic [IDX_BITS-1:0]   min_idx;
    logic [ID_BITS-1:0]    min_id;
    logic                  key_hit;
    logic                  key_lower;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    t_entry                mem_wdata;

    assign in_accept  = i_valid && !o_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_stall;
    assign table_full = (r_count >= CNT_BITS'(CAPACITY));
    assign o_valid    = r_out_valid;
    assign rd_entry   = t_entry'(rd_bits);

    // sequential walk over the held entries
    assign rd_en = ((r_state == ST_SCAN_MIN) || (r_state == ST_SCAN_KEY))
                   && (r_rd_idx < r_count);
    assign scan_last = r_cmp_valid
                       && (CNT_BITS'(r_cmp_idx) == (r_count - CNT_BITS'(1)));

    // running minimum; strict less-than keeps the earliest entry on ties
    assign min_take = (r_cmp_idx == '0) || (rd_entry.cost < r_best_cost);
    assign min_idx  = min_take ? r_cmp_idx   : r_best_idx;
    assign min_id   = min_take ? rd_entry.id : r_best_id;

    // id match for decrease-cost
    assign key_hit   = (rd_entry.id == r_key);
    assign key_lower = (r_new_cost < rd_entry.cost);

    // RAM write selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_BITS-1:0];
        mem_wdata = '{id: i_key_id, cost: i_cost};
        case (r_state)
            ST_IDLE: begin
                mem_we = in_accept && (t_action'(i_action) == ACT_INSERT) && !table_full;
            end
            ST_SCAN_MIN: begin
                // last entry moves into the slot of the minimum
                mem_we    = scan_last;
                mem_waddr = min_idx;
                mem_wdata = rd_entry;
            end
            ST_SCAN_KEY: begin
                mem_we    = r_cmp_valid && key_hit && key_lower;
                mem_waddr = r_cmp_idx;
                mem_wdata = '{id: r_key, cost: r_new_cost};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    ampq_entry_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_BITS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_BITS-1:0]),
        .o_rdata (rd_bits)
    );

    // control state, scan registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // read pipeline bookkeeping
            r_cmp_valid <= rd_en;
            if (rd_en) begin
                r_cmp_idx <= r_rd_idx[IDX_BITS-1:0];
                r_rd_idx  <= r_rd_idx + CNT_BITS'(1);
            end else if (r_state == ST_IDLE) begin
                r_rd_idx <= '0;
            end

            // output register empties once taken; ST_FINISH reloads it
            if (r_out_valid && !i_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_key         <= i_key_id;
                        r_new_cost    <= i_cost;
                        r_res_id      <= '0;
                        r_res_found   <= 1'b0;
                        r_res_dropped <= (t_action'(i_action) == ACT_INSERT) && table_full;
                        r_res_lowered <= 1'b0;
                        unique case (t_action'(i_action))
                            ACT_INSERT: begin
                                if (!table_full) begin
                                    r_count <= r_count + CNT_BITS'(1);
                                end
                                r_state <= ST_FINISH;
                            end
                            ACT_EXTRACT: begin
                                r_state <= (r_count == '0) ? ST_FINISH : ST_SCAN_MIN;
                            end
                            ACT_DECREASE: begin
                                r_state <= (r_count == '0) ? ST_FINISH : ST_SCAN_KEY;
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= ST_FINISH;
                            end
                            default: begin
                                r_state <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN_MIN: begin
                    if (r_cmp_valid) begin
                        r_best_idx  <= min_idx;
                        r_best_id   <= min_id;
                        r_best_cost <= min_take ? rd_entry.cost : r_best_cost;
                        if (scan_last) begin
                            r_res_id    <= min_id;
                            r_res_found <= 1'b1;
                            r_count     <= r_count - CNT_BITS'(1);
                            r_state     <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN_KEY: begin
                    if (r_cmp_valid) begin
                        if (key_hit) begin
                            r_res_lowered <= key_lower;
                            r_state       <= ST_FINISH;
                        end else if (scan_last) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    // hand the result to the output register once it is free
                    if (out_free) begin
                        o_out_id      <= r_res_id;
                        o_found       <= r_res_found;
                        o_dropped     <= r_res_dropped;
                        o_lowered     <= r_res_lowered;
                        o_entry_count <= r_count;
                        o_queue_empty <= (r_count == '0);
                        r_out_valid   <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count above capacity");

    // no RAM write while a result waits to be handed over
    a_no_write_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> !mem_we)
        else $error("entry write during result hand-over");

    // the minimum scan only runs over a non-empty table
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_MIN) |-> (r_count != '0))
        else $error("minimum scan over empty table");

    // a finished minimum scan always yields an entry
    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_MIN) && scan_last |=> r_res_found)
        else $error("minimum scan finished without an entry");

    // a result flags at most one outcome
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({o_found, o_dropped, o_lowered}))
        else $error("more than one outcome flag");
`endif

endmodule

// ===== rtl/ampq_entry_ram.sv =====
// ============================================================================
// ampq_entry_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ============================================================================
module ampq_entry_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the array min-priority queue. A shadow copy of the
// entry table predicts each result at the moment its word is accepted; the
// monitor compares every returned word field by field, in order. Stimulus is
// a short directed run followed by random insert/extract/decrease/clear
// sequences, including fills past capacity and drain runs, with random
// gaps on the input side and random stalls on the result side.
// ============================================================================
module tb;
    import ampq_pkg::*;

    localparam int N_WORDS      = 1900;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int TAIL_CYCLES  = CAPACITY + 16;

    typedef struct packed {
        t_action              act;
        logic [ID_BITS-1:0]   key_id;
        logic [COST_BITS-1:0] cost;
    } t_queue_cmd;

    typedef struct packed {
        logic [ID_BITS-1:0]  out_id;
        logic                found;
        logic                dropped;
        logic                lowered;
        logic [CNT_BITS-1:0] entry_count;
        logic                queue_empty;
    } t_queue_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_action;
    logic [ID_BITS-1:0]   i_key_id;
    logic [COST_BITS-1:0] i_cost;
    logic                 o_valid;
    logic                 i_stall;
    logic [ID_BITS-1:0]   o_out_id;
    logic                 o_found;
    logic                 o_dropped;
    logic                 o_lowered;
    logic [CNT_BITS-1:0]  o_entry_count;
    logic                 o_queue_empty;

    array_min_priority_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_key_id      (i_key_id),
        .i_cost        (i_cost),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_id      (o_out_id),
        .o_found       (o_found),
        .o_dropped     (o_dropped),
        .o_lowered     (o_lowered),
        .o_entry_count (o_entry_count),
        .o_queue_empty (o_queue_empty)
    );

    t_queue_cmd    queue_cmds[$];
    t_queue_result predicted_results[$];
    t_queue_cmd    cmd_on_bus;

    // shadow table of the queue
    logic [ID_BITS-1:0]   shadow_ids[CAPACITY];
    logic [COST_BITS-1:0] shadow_costs[CAPACITY];
    int                   shadow_count;

    // entry count as the stimulus generator sees it
    int gen_count;

    int  send_gap;
    bit  send_quiet;
    int  stall_left;
    bit  recv_quiet;
    bit  failed;
    longint cycle_count;

    // ------------------------------------------------------------------------
    // Queue behaviour: apply one word to the shadow table, return its result
    // ------------------------------------------------------------------------
    function automatic t_queue_result predict_result(t_queue_cmd w);
        t_queue_result r;
        int best;
        r = '0;
        case (w.act)
            ACT_INSERT: begin
                if (shadow_count < CAPACITY) begin
                    shadow_ids[shadow_count]   = w.key_id;
                    shadow_costs[shadow_count] = w.cost;
                    shadow_count++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            ACT_EXTRACT: begin
                if (shadow_count > 0) begin
                    // strict compare keeps the earliest entry on a tie
                    best = 0;
                    for (int i = 1; i < shadow_count; i++)
                        if (shadow_costs[i] < shadow_costs[best])
                            best = i;
                    r.out_id = shadow_ids[best];
                    r.found  = 1'b1;
                    shadow_ids[best]   = shadow_ids[shadow_count-1];
                    shadow_costs[best] = shadow_costs[shadow_count-1];
                    shadow_count--;
                end
            end
            ACT_DECREASE: begin
                // only the first entry with the id counts
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_ids[i] == w.key_id) begin
                        if (w.cost < shadow_costs[i]) begin
                            shadow_costs[i] = w.cost;
                            r.lowered = 1'b1;
                        end
                        break;
                    end
                end
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        r.entry_count = CNT_BITS'(shadow_count);
        r.queue_empty = (shadow_count == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_cmd(t_action a, logic [ID_BITS-1:0] id,
                                     logic [COST_BITS-1:0] c);
        t_queue_cmd w;
        w.act    = a;
        w.key_id = id;
        w.cost   = c;
        queue_cmds.push_back(w);
        case (a)
            ACT_INSERT:  if (gen_count < CAPACITY) gen_count++;
            ACT_EXTRACT: if (gen_count > 0) gen_count--;
            ACT_CLEAR:   gen_count = 0;
            default: ;
        endcase
    endfunction

    // mostly a small id pool so decrease-cost finds matches and duplicates
    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return ID_BITS'($urandom_range(0, 31));
        if (r < 8) return ID_BITS'($urandom_range(0, 255));
        if (r < 9) return ID_BITS'($urandom_range(0, 65535));
        return {ID_BITS{1'b1}};
    endfunction

    // small costs give ties, wide ones toggle every bit
    function automatic logic [COST_BITS-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return COST_BITS'($urandom_range(0, 15));
        if (r < 7) return COST_BITS'($urandom_range(0, 100000));
        if (r < 9) return COST_BITS'($urandom);
        return {COST_BITS{1'b1}} - COST_BITS'($urandom_range(0, 3));
    endfunction

    function automatic void build_directed();
        push_cmd(ACT_EXTRACT,  16'h0000, 32'h0000_0000);   // extract on empty
        push_cmd(ACT_DECREASE, 16'h0005, 32'h0000_0001);   // decrease on empty
        push_cmd(ACT_INSERT,   16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(ACT_INSERT,   16'h0000, 32'h0000_0000);
        push_cmd(ACT_INSERT,   16'h0005, 32'd100);
        push_cmd(ACT_INSERT,   16'h0005, 32'd50);          // duplicate id
        push_cmd(ACT_INSERT,   16'h0007, 32'd100);         // tie with first id 5
        push_cmd(ACT_DECREASE, 16'h0005, 32'd200);         // not smaller
        push_cmd(ACT_DECREASE, 16'h0005, 32'd100);         // equal, not lowered
        push_cmd(ACT_DECREASE, 16'h0009, 32'd1);           // no such id
        push_cmd(ACT_DECREASE, 16'h0005, 32'd60);          // lowers first entry only
        push_cmd(ACT_DECREASE, 16'hFFFF, 32'hFFFF_FFFE);
        push_cmd(ACT_EXTRACT,  16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        push_cmd(ACT_INSERT,   16'h0003, 32'd60);          // tie, later entry
        push_cmd(ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        push_cmd(ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        push_cmd(ACT_CLEAR,    16'hFFFF, 32'hFFFF_FFFF);
        push_cmd(ACT_CLEAR,    16'h0000, 32'h0000_0000);   // clear when empty
        push_cmd(ACT_EXTRACT,  16'h0000, 32'h0000_0000);
    endfunction

    function automatic void build_random();
        int r;
        int len;
        int fills;
        fills = 0;
        while (queue_cmds.size() < N_WORDS) begin
            r = $urandom_range(0, 9);
            if (r == 0 && fills < 3) begin
                // fill to capacity, overflow, then clear or leave for draining
                fills++;
                while (gen_count < CAPACITY) begin
                    if ($urandom_range(0, 9) == 0)
                        push_cmd(ACT_DECREASE, pick_id(), pick_cost());
                    else
                        push_cmd(ACT_INSERT, pick_id(), pick_cost());
                end
                repeat ($urandom_range(2, 5)) push_cmd(ACT_INSERT, pick_id(), pick_cost());
                push_cmd(ACT_DECREASE, pick_id(), pick_cost());
                if ($urandom_range(0, 1))
                    push_cmd(ACT_CLEAR, pick_id(), COST_BITS'($urandom));
            end else if (r < 3) begin
                // drain run of gen_count plus one to three words, mostly extracts, the odd decrease
                len = gen_count + $urandom_range(1, 3);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0)
                        push_cmd(ACT_DECREASE, pick_id(), pick_cost());
                    else
                        push_cmd(ACT_EXTRACT, ID_BITS'($urandom_range(0, 65535)),
                                 COST_BITS'($urandom));
                end
            end else begin
                // shortest-path style mix
                len = $urandom_range(20, 60);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        push_cmd(ACT_INSERT, pick_id(), pick_cost());
                    else if (r < 75)
                        push_cmd(ACT_EXTRACT, ID_BITS'($urandom_range(0, 65535)),
                                 COST_BITS'($urandom));
                    else if (r < 98)
                        push_cmd(ACT_DECREASE, pick_id(), pick_cost());
                    else
                        push_cmd(ACT_CLEAR, ID_BITS'($urandom_range(0, 65535)),
                                 COST_BITS'($urandom));
                end
            end
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: one word per handshake, random gaps between words
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_queue_cmd w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predicted_results.push_back(predict_result(cmd_on_bus));
            if ($urandom_range(0, 149) == 0)
                send_quiet <= !send_quiet;
            // a stalled word stays put
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (queue_cmds.size() > 0) begin
                    w = queue_cmds.pop_front();
                    cmd_on_bus <= w;
                    i_valid    <= 1'b1;
                    i_action   <= w.act;
                    i_key_id   <= w.key_id;
                    i_cost     <= w.cost;
                    send_gap   <= send_quiet ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result word, drive random stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_queue_result want;
        int r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_results.size() == 0) begin
                    $error("result word with nothing expected");
                    failed = 1'b1;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("out_id",      32'(want.out_id),      32'(o_out_id));
                    check_field("found",       32'(want.found),       32'(o_found));
                    check_field("dropped",     32'(want.dropped),     32'(o_dropped));
                    check_field("lowered",     32'(want.lowered),     32'(o_lowered));
                    check_field("entry_count", 32'(want.entry_count), 32'(o_entry_count));
                    check_field("queue_empty", 32'(want.queue_empty), 32'(o_queue_empty));
                end
            end
            if ($urandom_range(0, 199) == 0)
                recv_quiet <= !recv_quiet;
            if (recv_quiet) begin
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall    <= 1'b1;
                    stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build stimulus, reset, wait for every result, report
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = ACT_INSERT;
        i_key_id     = '0;
        i_cost       = '0;
        i_stall      = 1'b0;
        cmd_on_bus   = '0;
        shadow_count = 0;
        gen_count    = 0;
        send_gap     = 0;
        send_quiet   = 1'b0;
        stall_left   = 0;
        recv_quiet   = 1'b0;
        failed       = 1'b0;
        cycle_count  = 0;

        build_directed();
        build_random();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so the driver's updates have settled
        @(negedge i_clk);
        while (queue_cmds.size() != 0 || i_valid || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (failed)
            $display("FAIL");
        else
            $display("PASS");
        $finish;
    end

endmodule
